// ===== rtl/wrcp_pkg.sv =====
// Shared types, tag constants and codes for the WAV RIFF chunk parser.
package wrcp_pkg;

    // RIFF tags as little-endian 32-bit words
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [15:0] FORMAT_PCM = 16'd1;
    localparam logic [31:0] FMT_MIN    = 32'd16;

    // Byte positions inside the 36-byte header
    localparam logic [5:0] HB_RIFF  = 6'd3;
    localparam logic [5:0] HB_WAVE  = 6'd11;
    localparam logic [5:0] HB_FMT   = 6'd15;
    localparam logic [5:0] HB_FLEN  = 6'd19;
    localparam logic [5:0] HB_PCM   = 6'd21;
    localparam logic [5:0] HB_CHAN  = 6'd23;
    localparam logic [5:0] HB_RATE  = 6'd27;
    localparam logic [5:0] HB_LAST  = 6'd35;
    // Byte positions inside an 8-byte chunk header
    localparam logic [5:0] CB_TAG   = 6'd3;
    localparam logic [5:0] CB_LAST  = 6'd7;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_FORMAT  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_SHORT_HDR  = 3'd0;
    localparam logic [2:0] ERR_NOT_RIFF   = 3'd1;
    localparam logic [2:0] ERR_NOT_WAVE   = 3'd2;
    localparam logic [2:0] ERR_BAD_FMT    = 3'd3;
    localparam logic [2:0] ERR_NOT_PCM    = 3'd4;
    localparam logic [2:0] ERR_SHORT_DATA = 3'd5;

    // Result queue between the parser and the output stage
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Output word layout
    localparam int TDATA_W = 80;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_CHUNK,
        PH_DATA,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        chunk_last;
        logic [15:0] channels;
        logic [31:0] samp_rate;
        logic [15:0] sample_bits;
        logic [2:0]  error_code;
    } t_result;

endpackage

// ===== rtl/wrcp_front.sv =====
// Parser front end: classifies each accepted word and builds at most one result.
module wrcp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_eof,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output wrcp_pkg::t_result o_res
);

    wrcp_pkg::t_phase r_phase, n_phase;
    logic [5:0]  r_byte_count, n_byte_count;
    logic [31:0] r_word_shift, n_word_shift;
    logic [31:0] r_fmt_length, n_fmt_length;
    logic [15:0] r_channel_count, n_channel_count;
    logic [31:0] r_rate_word, n_rate_word;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [2:0]  r_fail, n_fail;        // first failed check plus one, zero when clean
    logic        r_is_data, n_is_data;  // last chunk tag was the data tag

    logic [31:0] w_word;
    logic [2:0]  w_fail_final;
    logic [31:0] w_skip_len;
    logic        w_left_one;

    assign w_word     = {i_byte, r_word_shift[31:8]};
    assign w_skip_len = r_fmt_length - wrcp_pkg::FMT_MIN;
    assign w_left_one = (r_bytes_left == 32'd1);

    // Fold in the fmt size check at the end of the header
    always_comb begin
        w_fail_final = r_fail;
        if (r_fail == 3'd0 && r_fmt_length < wrcp_pkg::FMT_MIN) begin
            w_fail_final = wrcp_pkg::ERR_BAD_FMT + 3'd1;
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_take) begin
            unique case (r_phase)
                wrcp_pkg::PH_HEADER: begin
                    if (i_eof) begin
                        n_phase = wrcp_pkg::PH_STOP;
                    end else if (r_byte_count == wrcp_pkg::HB_LAST) begin
                        if (w_fail_final != 3'd0) begin
                            n_phase = wrcp_pkg::PH_STOP;
                        end else if (w_skip_len != 32'd0) begin
                            n_phase = wrcp_pkg::PH_SKIP;
                        end else begin
                            n_phase = wrcp_pkg::PH_CHUNK;
                        end
                    end
                end
                wrcp_pkg::PH_SKIP: begin
                    if (i_eof) begin
                        n_phase = wrcp_pkg::PH_STOP;
                    end else if (w_left_one) begin
                        n_phase = wrcp_pkg::PH_CHUNK;
                    end
                end
                wrcp_pkg::PH_CHUNK: begin
                    if (i_eof) begin
                        n_phase = wrcp_pkg::PH_STOP;
                    end else if (r_byte_count >= wrcp_pkg::CB_LAST && w_word != 32'd0) begin
                        n_phase = r_is_data ? wrcp_pkg::PH_DATA : wrcp_pkg::PH_SKIP;
                    end
                end
                wrcp_pkg::PH_DATA: begin
                    if (i_eof) begin
                        n_phase = wrcp_pkg::PH_STOP;
                    end else if (w_left_one) begin
                        n_phase = wrcp_pkg::PH_CHUNK;
                    end
                end
                wrcp_pkg::PH_STOP: n_phase = wrcp_pkg::PH_STOP;
                default:           n_phase = wrcp_pkg::PH_STOP;
            endcase
        end
    end

    // Datapath registers: gather words, count bytes, latch header fields
    always_comb begin
        n_byte_count    = r_byte_count;
        n_word_shift    = r_word_shift;
        n_fmt_length    = r_fmt_length;
        n_channel_count = r_channel_count;
        n_rate_word     = r_rate_word;
        n_bytes_left    = r_bytes_left;
        n_fail          = r_fail;
        n_is_data       = r_is_data;
        if (i_take && !i_eof && r_phase != wrcp_pkg::PH_STOP) begin
            n_word_shift = w_word;
            case (r_phase)
                wrcp_pkg::PH_HEADER: begin
                    n_byte_count = r_byte_count + 6'd1;
                    case (r_byte_count)
                        wrcp_pkg::HB_RIFF: begin
                            if (w_word != wrcp_pkg::TAG_RIFF && r_fail == 3'd0) begin
                                n_fail = wrcp_pkg::ERR_NOT_RIFF + 3'd1;
                            end
                        end
                        wrcp_pkg::HB_WAVE: begin
                            if (w_word != wrcp_pkg::TAG_WAVE && r_fail == 3'd0) begin
                                n_fail = wrcp_pkg::ERR_NOT_WAVE + 3'd1;
                            end
                        end
                        wrcp_pkg::HB_FMT: begin
                            if (w_word != wrcp_pkg::TAG_FMT && r_fail == 3'd0) begin
                                n_fail = wrcp_pkg::ERR_BAD_FMT + 3'd1;
                            end
                        end
                        wrcp_pkg::HB_FLEN: n_fmt_length = w_word;
                        wrcp_pkg::HB_PCM: begin
                            if (w_word[31:16] != wrcp_pkg::FORMAT_PCM && r_fail == 3'd0) begin
                                n_fail = wrcp_pkg::ERR_NOT_PCM + 3'd1;
                            end
                        end
                        wrcp_pkg::HB_CHAN: n_channel_count = w_word[31:16];
                        wrcp_pkg::HB_RATE: n_rate_word = w_word;
                        wrcp_pkg::HB_LAST: begin
                            n_byte_count = 6'd0;
                            n_fail       = w_fail_final;
                            n_bytes_left = w_skip_len;
                        end
                        default: ;
                    endcase
                end
                wrcp_pkg::PH_SKIP: n_bytes_left = r_bytes_left - 32'd1;
                wrcp_pkg::PH_CHUNK: begin
                    n_byte_count = r_byte_count + 6'd1;
                    if (r_byte_count == wrcp_pkg::CB_TAG) begin
                        n_is_data = (w_word == wrcp_pkg::TAG_DATA);
                    end else if (r_byte_count >= wrcp_pkg::CB_LAST) begin
                        n_byte_count = 6'd0;
                        n_bytes_left = w_word;
                    end
                end
                wrcp_pkg::PH_DATA: begin
                    n_bytes_left = r_bytes_left - 32'd1;
                    if (w_left_one) begin
                        n_byte_count = 6'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result for this word
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_take && r_phase != wrcp_pkg::PH_STOP) begin
            if (i_eof) begin
                o_res_valid = 1'b1;
                case (r_phase)
                    wrcp_pkg::PH_HEADER: begin
                        o_res.kind       = wrcp_pkg::KIND_ERROR;
                        o_res.error_code = wrcp_pkg::ERR_SHORT_HDR;
                    end
                    wrcp_pkg::PH_DATA: begin
                        o_res.kind       = wrcp_pkg::KIND_ERROR;
                        o_res.error_code = wrcp_pkg::ERR_SHORT_DATA;
                    end
                    default: o_res.kind = wrcp_pkg::KIND_END;
                endcase
            end else if (r_phase == wrcp_pkg::PH_HEADER
                         && r_byte_count == wrcp_pkg::HB_LAST) begin
                o_res_valid = 1'b1;
                if (w_fail_final != 3'd0) begin
                    o_res.kind       = wrcp_pkg::KIND_ERROR;
                    o_res.error_code = w_fail_final - 3'd1;
                end else begin
                    o_res.kind        = wrcp_pkg::KIND_FORMAT;
                    o_res.channels    = r_channel_count;
                    o_res.samp_rate   = r_rate_word;
                    o_res.sample_bits = w_word[31:16];
                end
            end else if (r_phase == wrcp_pkg::PH_DATA) begin
                o_res_valid      = 1'b1;
                o_res.kind       = wrcp_pkg::KIND_PAYLOAD;
                o_res.data_byte  = i_byte;
                o_res.chunk_last = w_left_one;
            end
        end
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= wrcp_pkg::PH_HEADER;
            r_byte_count    <= '0;
            r_word_shift    <= '0;
            r_fmt_length    <= '0;
            r_channel_count <= '0;
            r_rate_word     <= '0;
            r_bytes_left    <= '0;
            r_fail          <= '0;
            r_is_data       <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_byte_count    <= n_byte_count;
            r_word_shift    <= n_word_shift;
            r_fmt_length    <= n_fmt_length;
            r_channel_count <= n_channel_count;
            r_rate_word     <= n_rate_word;
            r_bytes_left    <= n_bytes_left;
            r_fail          <= n_fail;
            r_is_data       <= n_is_data;
        end
    end

endmodule

// ===== rtl/wrcp_queue.sv =====
// Short result queue between the parser and the output stage.
module wrcp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wrcp_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output wrcp_pkg::t_result o_data
);

    wrcp_pkg::t_result r_mem [wrcp_pkg::QDEPTH];
    logic [wrcp_pkg::QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [wrcp_pkg::QAW:0]   r_count;

    assign o_full  = (r_count == (wrcp_pkg::QAW+1)'(wrcp_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + wrcp_pkg::QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + wrcp_pkg::QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (wrcp_pkg::QAW+1)'(1);
                2'b01:   r_count <= r_count - (wrcp_pkg::QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/wrcp_back.sv =====
// Output stage: registers one result and packs it onto the master stream.
module wrcp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  wrcp_pkg::t_result             i_q_data,
    output logic                          o_q_pop,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [wrcp_pkg::TDATA_W-1:0]  o_tdata,
    output logic [1:0]                    o_tuser,
    output logic                          o_tlast
);

    logic              r_valid;
    wrcp_pkg::t_result r_res;
    logic              w_load;

    // Refill when the register is empty or its word leaves this cycle
    assign w_load  = !i_q_empty && (!r_valid || i_tready);
    assign o_q_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_q_data;
        end
    end

    // Pack: data_byte, channels, samp_rate, sample_bits, error_code, zero fill
    assign o_tvalid = r_valid;
    assign o_tuser  = r_res.kind;
    assign o_tlast  = r_res.chunk_last;
    assign o_tdata  = {5'd0, r_res.error_code, r_res.sample_bits, r_res.samp_rate,
                       r_res.channels, r_res.data_byte};

endmodule

// ===== rtl/wav_riff_chunk_parser_unit.sv =====
// Top level of the WAV RIFF chunk parser: parser, result queue and output stage.
//
//  Channel   Dir  tdata                     tuser          tlast
//  s_axis    in   byte_value[7:0]           action[0]      -
//  m_axis    out  data_byte, channels,      kind[1:0]      chunk_last
//                 samp_rate, sample_bits,
//                 error_code, zero fill
//
// One input word per cycle while the queue has room; the parser decides each word in
// the cycle it is taken. A result passes the queue, then the output register.
// s_axis_tready drops only while the four-entry result queue is full.
// Reset is synchronous, active low; after an error or end of stream, words are
// taken and dropped until reset.
module wav_riff_chunk_parser_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // byte_value[7:0]
    input  logic [0:0]                   s_axis_tuser,   // action[0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // data_byte[7:0], channels[23:8], samp_rate[55:24], sample_bits[71:56],
    // error_code[74:72], zero [79:75]
    output logic [wrcp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,   // kind[1:0]
    output logic                         m_axis_tlast    // chunk_last
);

    logic              w_take;
    logic              w_res_valid;
    wrcp_pkg::t_result w_res;
    logic              w_q_full, w_q_empty, w_q_pop;
    wrcp_pkg::t_result w_q_data;

    assign s_axis_tready = !w_q_full;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    wrcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_eof       (s_axis_tuser[0]),
        .i_byte      (s_axis_tdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wrcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    wrcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the WAV RIFF chunk parser: random files, scoreboard, stalls.
module tb_top;
    import wrcp_pkg::*;

    localparam int WORDS_TARGET = 1150;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_EVERY   = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;

    // Keeps its own copy of the parser state and the results still owed by the block
    class wav_parse_scoreboard;
        // Byte positions inside the header and inside a chunk header
        localparam int POS_RIFF = 3;
        localparam int POS_WAVE = 11;
        localparam int POS_FMT  = 15;
        localparam int POS_FLEN = 19;
        localparam int POS_CODE = 21;
        localparam int POS_CHAN = 23;
        localparam int POS_RATE = 27;
        localparam int POS_HEND = 35;
        localparam int POS_CTAG = 3;
        localparam int POS_CEND = 7;

        t_phase      phase;
        logic [5:0]  byte_pos;
        logic [31:0] shift_word;
        logic [31:0] fmt_len;
        logic [15:0] chan_count;
        logic [31:0] rate_val;
        logic [15:0] bits_val;
        logic [31:0] tag_word;
        logic [31:0] remaining;
        bit          fail_seen;
        logic [2:0]  fail_code;
        t_result     awaited_results[$];
        int          fail_count;

        function new();
            phase      = PH_HEADER;
            byte_pos   = '0;
            shift_word = '0;
            fmt_len    = '0;
            chan_count = '0;
            rate_val   = '0;
            bits_val   = '0;
            tag_word   = '0;
            remaining  = '0;
            fail_seen  = 1'b0;
            fail_code  = '0;
            fail_count = 0;
        endfunction

        // Keep only the first failed header check
        function void record_fail(logic [2:0] code);
            if (!fail_seen) begin
                fail_seen = 1'b1;
                fail_code = code;
            end
        endfunction

        // Advance the parser by one word; return 1 when it yields a result
        function bit predict_parse(bit eof, logic [7:0] b, output t_result r);
            int     pos;
            t_phase was;
            r = '0;
            if (phase == PH_STOP) return 1'b0;

            // End of file: the phase decides between an error and a clean end
            if (eof) begin
                was   = phase;
                phase = PH_STOP;
                if (was == PH_HEADER) begin
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_SHORT_HDR;
                end else if (was == PH_DATA) begin
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_SHORT_DATA;
                end else begin
                    r.kind = KIND_END;
                end
                return 1'b1;
            end

            shift_word = {b, shift_word[31:8]};

            case (phase)
                PH_HEADER: begin
                    pos      = int'(byte_pos);
                    byte_pos = byte_pos + 6'd1;
                    case (pos)
                        POS_RIFF: if (shift_word != TAG_RIFF) record_fail(ERR_NOT_RIFF);
                        POS_WAVE: if (shift_word != TAG_WAVE) record_fail(ERR_NOT_WAVE);
                        POS_FMT:  if (shift_word != TAG_FMT) record_fail(ERR_BAD_FMT);
                        POS_FLEN: fmt_len = shift_word;
                        POS_CODE: if (shift_word[31:16] != FORMAT_PCM) record_fail(ERR_NOT_PCM);
                        POS_CHAN: chan_count = shift_word[31:16];
                        POS_RATE: rate_val = shift_word;
                        POS_HEND: bits_val = shift_word[31:16];
                        default: ;
                    endcase
                    if (pos != POS_HEND) return 1'b0;
                    byte_pos = '0;
                    if (!fail_seen && fmt_len < 32'd16) record_fail(ERR_BAD_FMT);
                    if (fail_seen) begin
                        phase        = PH_STOP;
                        r.kind       = KIND_ERROR;
                        r.error_code = fail_code;
                        return 1'b1;
                    end
                    remaining     = fmt_len - 32'd16;
                    phase         = (remaining != 0) ? PH_SKIP : PH_CHUNK;
                    r.kind        = KIND_FORMAT;
                    r.channels    = chan_count;
                    r.samp_rate   = rate_val;
                    r.sample_bits = bits_val;
                    return 1'b1;
                end
                PH_SKIP: begin
                    remaining = remaining - 32'd1;
                    if (remaining == 0) phase = PH_CHUNK;
                    return 1'b0;
                end
                PH_CHUNK: begin
                    pos      = int'(byte_pos);
                    byte_pos = byte_pos + 6'd1;
                    if (pos == POS_CTAG) begin
                        tag_word = shift_word;
                    end else if (pos >= POS_CEND) begin
                        byte_pos  = '0;
                        remaining = shift_word;
                        if (remaining == 0) phase = PH_CHUNK;
                        else if (tag_word == TAG_DATA) phase = PH_DATA;
                        else phase = PH_SKIP;
                    end
                    return 1'b0;
                end
                PH_DATA: begin
                    remaining   = remaining - 32'd1;
                    r.kind      = KIND_PAYLOAD;
                    r.data_byte = b;
                    if (remaining == 0) begin
                        r.chunk_last = 1'b1;
                        phase        = PH_CHUNK;
                        byte_pos     = '0;
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        // Note an accepted input word
        function void note_word(bit eof, logic [7:0] b);
            t_result r;
            if (predict_parse(eof, b, r)) awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                fail_count++;
                $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        // Check an accepted result word against the oldest one owed
        function void check_word(t_result got, logic [4:0] fill);
            t_result want;
            if (awaited_results.size() == 0) begin
                fail_count++;
                $display("%0t  unexpected result: expected none, actual kind %0h data %0h",
                         $time, got.kind, got.data_byte);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("chunk_last", want.chunk_last, got.chunk_last);
            compare_field("channels", want.channels, got.channels);
            compare_field("samp_rate", want.samp_rate, got.samp_rate);
            compare_field("sample_bits", want.sample_bits, got.sample_bits);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("zero_fill", 32'd0, fill);
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // byte_value[7:0]
    logic [0:0]           s_axis_tuser;   // action[0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;   // data_byte, channels, samp_rate, sample_bits, error_code
    logic [1:0]           m_axis_tuser;   // kind[1:0]
    logic                 m_axis_tlast;   // chunk_last

    wav_parse_scoreboard sb;
    int                  in_gap      = 0;
    int                  words_sent  = 0;
    bit                  hold_req    = 1'b0;
    int                  quiet_cycles = 0;

    wav_riff_chunk_parser_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Idle gap per word, with regular stretches of back-to-back traffic
    function automatic int draw_gap(int n);
        if ((n % 96) < 24) return 0;
        return $urandom_range(0, 6);
    endfunction

    // Payload byte biased towards the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_u32(logic [31:0] typical);
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return typical;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word and hold it until taken
    task automatic send_word(input bit eof, input logic [7:0] val);
        if (in_gap > 0) repeat (in_gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= eof;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(eof, val);
        words_sent++;
        in_gap = draw_gap(words_sent);
        if (in_gap > 0) s_axis_tvalid <= 1'b0;
    endtask

    // Send the low bytes of a value, least significant first
    task automatic send_le(input logic [63:0] value, input int count);
        for (int k = 0; k < count; k++) send_word(1'b0, value[8*k +: 8]);
    endtask

    task automatic send_chunk(input logic [31:0] tag, input logic [31:0] size, input int nsend);
        send_le({size, tag}, 8);
        repeat (nsend) send_word(1'b0, pick_byte());
    endtask

    // 36-byte header, optionally spoiled in one or more of its checks
    task automatic send_header(input bit broken);
        logic [4:0]  spoil;
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic [31:0] fmt_tag;
        logic [31:0] fmt_len_field;
        logic [15:0] fmt_code;
        int          ext;
        spoil    = broken ? 5'($urandom_range(1, 31)) : 5'd0;
        riff_tag = spoil[0] ? TAG_RIFF ^ (32'h1 << $urandom_range(0, 31)) : TAG_RIFF;
        wave_tag = spoil[1] ? TAG_WAVE ^ (32'h1 << $urandom_range(0, 31)) : TAG_WAVE;
        fmt_tag  = spoil[2] ? TAG_FMT ^ (32'h1 << $urandom_range(0, 31)) : TAG_FMT;
        fmt_code = spoil[3] ? ($urandom_range(0, 1) ? 16'h0000 : 16'($urandom_range(2, 65535)))
                            : FORMAT_PCM;
        ext      = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        fmt_len_field = spoil[4] ? 32'($urandom_range(0, 15)) : 32'(16 + ext);
        send_le(riff_tag, 4);
        send_le($urandom, 4);
        send_le(wave_tag, 4);
        send_le(fmt_tag, 4);
        send_le(fmt_len_field, 4);
        send_le(fmt_code, 2);
        send_le(pick_u32(32'd2), 2);
        send_le(pick_u32(32'd44100), 4);
        send_le($urandom, 4);
        send_le($urandom_range(0, 65535), 2);
        send_le(pick_u32(32'd16), 2);
        if (!broken) repeat (ext) send_word(1'b0, pick_byte());
    endtask

    // Tag for a chunk that is not audio data
    function automatic logic [31:0] other_tag();
        case ($urandom_range(0, 3))
            0: return TAG_DATA ^ (32'h1 << $urandom_range(0, 31));
            1: return TAG_FMT;
            2: return TAG_LIST;
            default: return $urandom;
        endcase
    endfunction

    // Drive reset and the input stream, then judge the run
    initial begin : stimulus
        int          header_mode;
        int          end_mode;
        int          size;
        int          next_hold_at;
        logic [31:0] tag;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Mostly a sound header; now and then a truncated or spoiled one
        header_mode = $urandom_range(0, 9);
        if (header_mode == 0) begin
            repeat ($urandom_range(0, 35)) send_word(1'b0, pick_byte());
            send_word(1'b1, pick_byte());
        end else begin
            send_header(header_mode == 1);
        end

        // Empty chunks, a one-byte data chunk and extreme payload bytes
        send_chunk(TAG_LIST, 32'd0, 0);
        send_chunk(TAG_DATA, 32'd0, 0);
        send_chunk(TAG_DATA, 32'd1, 1);
        send_le({32'd2, TAG_DATA}, 8);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hFF);

        // Random chunk sequence, mostly audio data
        next_hold_at = 300;
        while (words_sent < WORDS_TARGET) begin
            if (words_sent >= next_hold_at) begin
                hold_req     = 1'b1;
                next_hold_at = next_hold_at + HOLD_EVERY;
            end
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 19))
                    0: size = 0;
                    1: size = 1;
                    2: size = $urandom_range(20, 40);
                    default: size = $urandom_range(2, 12);
                endcase
                send_chunk(TAG_DATA, size, size);
            end else begin
                size = $urandom_range(0, 8);
                send_chunk(other_tag(), size, size);
            end
        end

        // Finish the file in a random phase
        end_mode = $urandom_range(0, 3);
        case (end_mode)
            0: ;
            1: send_le({$urandom, other_tag()}, $urandom_range(1, 7));
            2: begin
                size = $urandom_range(0, 10);
                send_chunk(TAG_DATA, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(size + 1), size);
            end
            default: begin
                size = $urandom_range(0, 19);
                send_chunk(other_tag(), 32'd20, size);
            end
        endcase
        send_word(1'b1, pick_byte());

        // Words after the end are dropped without a result
        repeat (6) send_word(1'($urandom_range(0, 1)), pick_byte());
        if (in_gap == 0) s_axis_tvalid <= 1'b0;

        // Drain, then allow the pipeline to settle
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending_count() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Take result words with random stalls and the occasional long hold-off
    initial begin : result_sink
        int      stall;
        int      results_seen;
        t_result got;
        results_seen  = 0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = draw_gap(results_seen);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.kind        = m_axis_tuser;
            got.data_byte   = m_axis_tdata[7:0];
            got.chunk_last  = m_axis_tlast;
            got.channels    = m_axis_tdata[23:8];
            got.samp_rate   = m_axis_tdata[55:24];
            got.sample_bits = m_axis_tdata[71:56];
            got.error_code  = m_axis_tdata[74:72];
            sb.check_word(got, m_axis_tdata[79:75]);
            results_seen++;
        end
    end

    // Abort when neither side has moved a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t  timeout: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
rtl/wrcp_pkg.sv
rtl/wrcp_front.sv
rtl/wrcp_queue.sv
rtl/wrcp_back.sv
rtl/wav_riff_chunk_parser_unit.sv
test/tb_top.sv
